[sv/deq_pkg.sv]
// operation codes, status codes and sequencer states for the double-ended queue
`default_nettype none
package deq_pkg;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_REAR   = 3'd3;
	localparam logic [2:0] KIND_DUMP       = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_POP,
		SEQ_DUMP
	} seq_state_t;

endpackage
`default_nettype wire

[sv/deq_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/double_ended_queue_top.sv]
// double-ended queue of signed words kept in a ring ram
//
// channel   direction  beat marked by        payload
// command   in         start && !busy        kind, push_value
// result    out        out_valid (1 cycle)   out_value, status, last_of_run
//
// push, failed pop, empty dump: busy stays low, result registered in the cycle after the beat
// pop: result passes through the registered ram read and the SEQ_POP state, busy high for one cycle
// dump of n words: one result per cycle once the first word is read, busy high meanwhile
// reset clears head, count and sequencer; ram contents stay undefined until pushed
// results cannot be stalled; out_valid lasts exactly one cycle per result
`default_nettype none
module double_ended_queue_top #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic        [2:0]  kind,
	input  wire logic signed [31:0] push_value,
	output logic                    out_valid,
	output logic signed      [31:0] out_value,
	output logic             [1:0]  status,
	output logic                    last_of_run
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	deq_pkg::seq_state_t state_q, state_d;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] remain_q;

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] rear_slot;
	logic [AW-1:0] last_slot;
	logic [AW-1:0] ptr_inc;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign accept    = start && !busy;
	assign is_full   = (count_q == CW'(DEPTH));
	assign is_empty  = (count_q == '0);
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc  = wrap_add(head_q, CW'(1));
	assign rear_slot = wrap_add(head_q, count_q);
	assign last_slot = wrap_add(head_q, count_q - 1'b1);
	assign ptr_inc   = wrap_add(ptr_q, CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::SEQ_IDLE: begin
				if (accept && !is_empty) begin
					case (kind) inside
						deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR: state_d = deq_pkg::SEQ_POP;
						deq_pkg::KIND_DUMP: state_d = deq_pkg::SEQ_DUMP;
						default: state_d = deq_pkg::SEQ_IDLE;
					endcase
				end
			end
			deq_pkg::SEQ_POP: begin
				state_d = deq_pkg::SEQ_IDLE;
			end
			deq_pkg::SEQ_DUMP: begin
				if (remain_q == CW'(1)) begin
					state_d = deq_pkg::SEQ_IDLE;
				end
			end
			default: state_d = deq_pkg::SEQ_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		busy      = (state_q != deq_pkg::SEQ_IDLE);
		ram_we    = 1'b0;
		ram_waddr = rear_slot;
		ram_raddr = head_q;
		unique case (state_q)
			deq_pkg::SEQ_IDLE: begin
				if (kind == deq_pkg::KIND_PUSH_FRONT) begin
					ram_waddr = head_dec;
				end
				if (kind == deq_pkg::KIND_POP_REAR) begin
					ram_raddr = last_slot;
				end
				if (accept && !is_full &&
				    (kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_REAR)) begin
					ram_we = 1'b1;
				end
			end
			deq_pkg::SEQ_DUMP: begin
				ram_raddr = ptr_q;
			end
			default: begin
				ram_raddr = head_q;
			end
		endcase
	end

	deq_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (push_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= deq_pkg::SEQ_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			ptr_q     <= '0;
			remain_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			out_valid <= 1'b0;
			if (state_q == deq_pkg::SEQ_IDLE && accept) begin
				case (kind) inside
					deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
						out_valid <= 1'b1;
						if (!is_full) begin
							count_q <= count_q + 1'b1;
							if (kind == deq_pkg::KIND_PUSH_FRONT) begin
								head_q <= head_dec;
							end
						end
					end
					deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR: begin
						if (is_empty) begin
							out_valid <= 1'b1;
						end else begin
							count_q <= count_q - 1'b1;
							if (kind == deq_pkg::KIND_POP_FRONT) begin
								head_q <= head_inc;
							end
						end
					end
					deq_pkg::KIND_DUMP: begin
						if (is_empty) begin
							out_valid <= 1'b1;
						end
						ptr_q    <= head_inc;
						remain_q <= count_q;
					end
					default: begin
						out_valid <= 1'b0;
					end
				endcase
			end else if (state_q == deq_pkg::SEQ_POP) begin
				out_valid <= 1'b1;
			end else if (state_q == deq_pkg::SEQ_DUMP) begin
				out_valid <= 1'b1;
				ptr_q     <= ptr_inc;
				remain_q  <= remain_q - 1'b1;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == deq_pkg::SEQ_IDLE) begin
			out_value   <= '0;
			last_of_run <= 1'b1;
			if (kind == deq_pkg::KIND_PUSH_FRONT || kind == deq_pkg::KIND_PUSH_REAR) begin
				status <= is_full ? deq_pkg::STATUS_FULL : deq_pkg::STATUS_OK;
			end else begin
				status <= deq_pkg::STATUS_EMPTY;
			end
		end else begin
			out_value   <= ram_rdata;
			status      <= deq_pkg::STATUS_OK;
			last_of_run <= (state_q == deq_pkg::SEQ_POP) || (remain_q == CW'(1));
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("item count above depth");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !is_full)
		else $error("ring write while full");

	a_dump_streams: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == deq_pkg::SEQ_DUMP) |=> out_valid)
		else $error("dump cycle without a result");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_run) |-> (state_q == deq_pkg::SEQ_IDLE))
		else $error("final result while sequencer still busy");

endmodule
`default_nettype wire
